@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds on the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg
// Types, request codes and constants of the keyboard scancode translator.
// ----------------------------------------------------------------------------
package kst_pkg;

  // Parameter defaults
  localparam int RING_DEPTH_DEF  = 16;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ROW_LENGTH      = 96;

  // Field widths
  localparam int REQ_W   = 3;
  localparam int KEY_W   = 8;
  localparam int GROUP_W = 4;
  localparam int TADDR_W = 10;
  localparam int TVAL_W  = 8;
  localparam int CODE_W  = 16;
  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 5;
  localparam int ROW_W   = 3;
  localparam int RETRY_W = 2;
  localparam int GROUPS  = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SCAN   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RXERR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GROUP  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TWRITE = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd6;

  // Scancode landmarks
  localparam logic [KEY_W-1:0] KEY_DIRECT_LAST = 8'h51;
  localparam logic [KEY_W-1:0] KEY_HIGH_A      = 8'h35;
  localparam logic [KEY_W-1:0] KEY_HIGH_B      = 8'h3E;
  localparam logic [KEY_W-1:0] KEY_FIXED       = 8'h5E;
  localparam logic [KEY_W-1:0] KEY_SHIFTED_LO  = 8'h62;
  localparam logic [KEY_W-1:0] KEY_SHIFTED_HI  = 8'h6F;
  localparam logic [KEY_W-1:0] KEY_SHIFTED_OFS = 8'h0C;
  localparam logic [KEY_W-1:0] KEY_SHIFT_L     = 8'h70;
  localparam logic [KEY_W-1:0] KEY_SHIFT_R     = 8'h7D;
  localparam logic [KEY_W-1:0] KEY_MOD_LO      = 8'h71;
  localparam logic [KEY_W-1:0] KEY_MOD_HI      = 8'h74;
  localparam logic [KEY_W-1:0] BRK_SHIFT_L     = 8'hF0;
  localparam logic [KEY_W-1:0] BRK_SHIFT_R     = 8'hFD;
  localparam logic [KEY_W-1:0] BRK_MOD_LO      = 8'hF1;
  localparam logic [KEY_W-1:0] BRK_MOD_HI      = 8'hF4;
  localparam logic [TVAL_W-1:0] TBL_NO_CODE    = 8'hFF;
  localparam logic [CODE_W-1:0] CODE_FIXED     = 16'hAE00;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT   = 2'd3;

  // Ring command from the sequencer
  typedef struct packed {
    logic              rd_en;  // read entry at head
    logic              push;   // append wdata when not full
    logic              pop;    // drop entry at head
    logic              clear;  // empty the ring
    logic [CODE_W-1:0] wdata;
  } ring_cmd_t;

  // Translate row from the shift state
  function automatic logic [ROW_W-1:0] pick_row(input logic [SHIFT_W-1:0] s);
    logic [ROW_W-1:0] r;
    if (s[4]) begin
      r = 3'd7;
    end else if (s[3]) begin
      r = 3'd6;
    end else begin
      r = s[2:0];
      if (r >= 3'd6) r = r - 3'd2;
    end
    return r;
  endfunction

endpackage

@@ src/kst_if.sv @@
// ----------------------------------------------------------------------------
// kst_if
// Valid/ready channels for translator requests and results.
// ----------------------------------------------------------------------------
interface kst_in_if;
  logic                          valid;
  logic                          ready;
  logic [kst_pkg::REQ_W-1:0]     req_type;
  logic [kst_pkg::KEY_W-1:0]     scancode;
  logic [kst_pkg::GROUP_W-1:0]   key_group;
  logic [kst_pkg::TADDR_W-1:0]   table_index;
  logic [kst_pkg::TVAL_W-1:0]    table_value;

  modport source (output valid, req_type, scancode, key_group, table_index,
                  table_value, input ready);
  modport sink   (input valid, req_type, scancode, key_group, table_index,
                  table_value, output ready);
endinterface

interface kst_out_if;
  logic                          valid;
  logic                          ready;
  logic [kst_pkg::CODE_W-1:0]    key_code;
  logic                          key_valid;
  logic [kst_pkg::SHIFT_W-1:0]   shift_state;
  logic [7:0]                    key_state_byte;
  logic                          retry_request;
  logic [kst_pkg::COUNT_W-1:0]   buffer_count;
  logic [kst_pkg::ROW_W-1:0]     table_select;

  modport source (output valid, key_code, key_valid, shift_state, key_state_byte,
                  retry_request, buffer_count, table_select, input ready);
  modport sink   (input valid, key_code, key_valid, shift_state, key_state_byte,
                  retry_request, buffer_count, table_select, output ready);
endinterface

@@ src/kst_table.sv @@
// ----------------------------------------------------------------------------
// kst_table
// Translate table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kst_table #(
  parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [kst_pkg::TADDR_W-1:0]  rd_addr,
  input  logic                         wr_en,
  input  logic [kst_pkg::TADDR_W-1:0]  wr_addr,
  input  logic [kst_pkg::TVAL_W-1:0]   wr_data,
  output logic [kst_pkg::TVAL_W-1:0]   rd_data
);

  logic [kst_pkg::TVAL_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [kst_pkg::TVAL_W-1:0] rd_data_r;

  // write port; caller keeps wr_addr below TABLE_DEPTH
  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
  end

  // read port, registered, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= tbl_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/kst_ring.sv @@
// ----------------------------------------------------------------------------
// kst_ring
// Key code ring: storage array, head/tail pointers and fill count.
// ----------------------------------------------------------------------------
module kst_ring #(
  parameter int  RING_DEPTH = kst_pkg::RING_DEPTH_DEF,
  localparam int FILL_W     = $clog2(RING_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kst_pkg::ring_cmd_t          cmd,
  output logic [kst_pkg::CODE_W-1:0]  rd_data,
  output logic [FILL_W-1:0]           fill,
  output logic [FILL_W-1:0]           fill_nxt
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);

  logic [kst_pkg::CODE_W-1:0] ring_mem [RING_DEPTH];
  logic [kst_pkg::CODE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [PTR_W-1:0]           tail_r, tail_nxt;
  logic [FILL_W-1:0]          fill_r;
  logic                       push_ok, pop_ok;

  assign push_ok = cmd.push && (fill_r != FILL_MAX);
  assign pop_ok  = cmd.pop && (fill_r != '0);

  // pointer and count update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end else if (push_ok) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (pop_ok) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (push_ok && !cmd.clear) ring_mem[tail_r] <= cmd.wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= ring_mem[head_r];
  end

  assign rd_data = rd_data_r;
  assign fill    = fill_r;

endmodule

@@ src/keyboard_scancode_translator_fifo_core.sv @@
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_fifo_core
// Scancode translator with pressed-key map, shift state and key code ring.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  in_req    in   valid/ready    req_type, scancode, key_group, table index/value
//  out_rsp   out  valid/ready    key code, shift state, key byte, retry, count, row
//
// A request is accepted in IDLE: the accept edge issues the table and ring
// reads; the commit edge in EXEC updates state, ring and the result register.
// The commit waits while a previous result sits unread in the output register.
// Reset is synchronous; the translate table keeps its contents over reset and
// over the clear request. Reads never overlap writes, so no forwarding exists.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_scancode_translator_fifo_core #(
  parameter int RING_DEPTH  = kst_pkg::RING_DEPTH_DEF,
  parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  kst_in_if.sink       in_req,
  kst_out_if.source    out_rsp
);

  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic accept, commit;

  // latched request
  logic [kst_pkg::REQ_W-1:0]   req_type_r;
  logic [kst_pkg::KEY_W-1:0]   scancode_r;
  logic [kst_pkg::GROUP_W-1:0] key_group_r;
  logic [kst_pkg::TADDR_W-1:0] table_index_r;
  logic [kst_pkg::TVAL_W-1:0]  table_value_r;

  // keyboard state
  logic [7:0]                  pressed_r   [kst_pkg::GROUPS];
  logic [7:0]                  pressed_nxt [kst_pkg::GROUPS];
  logic [kst_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [kst_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [kst_pkg::RETRY_W-1:0] retry_r, retry_nxt;

  // result register
  logic                        out_valid_r;
  logic [kst_pkg::CODE_W-1:0]  key_code_r, key_code_nxt;
  logic                        key_valid_r, key_valid_nxt;
  logic [7:0]                  state_byte_r, state_byte_nxt;
  logic                        retry_req_r, retry_req_nxt;
  logic [kst_pkg::COUNT_W-1:0] count_r;

  // memories
  kst_pkg::ring_cmd_t          ring_cmd;
  logic [kst_pkg::CODE_W-1:0]  ring_rdata;
  logic [FILL_W-1:0]           ring_fill, ring_fill_nxt;
  logic                        tbl_rd_en, tbl_wr_en;
  logic [kst_pkg::TADDR_W-1:0] tbl_rd_addr;
  logic [kst_pkg::TVAL_W-1:0]  tbl_rdata;
  logic [6:0]                  tbl_ofs;
  logic                        code_ok;
  logic [kst_pkg::CODE_W-1:0]  code_val;

  // handshake and sequencing
  assign in_req.ready = (state_r == ST_IDLE);
  assign accept = in_req.valid && in_req.ready;
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt = state_r;
    if (accept) state_nxt = ST_EXEC;
    else if (commit) state_nxt = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r    <= in_req.req_type;
      scancode_r    <= in_req.scancode;
      key_group_r   <= in_req.key_group;
      table_index_r <= in_req.table_index;
      table_value_r <= in_req.table_value;
    end
  end

  // table read address at accept: row * 96 + offset
  always_comb begin
    if (in_req.scancode <= kst_pkg::KEY_DIRECT_LAST) begin
      tbl_ofs = in_req.scancode[6:0];
    end else begin
      tbl_ofs = in_req.scancode[6:0] - kst_pkg::KEY_SHIFTED_OFS[6:0];
    end
    tbl_rd_addr = {1'b0, row_r, 6'b0} + {2'b0, row_r, 5'b0} + {3'b0, tbl_ofs};
  end

  assign tbl_rd_en = accept && (in_req.req_type == kst_pkg::REQ_SCAN);
  assign tbl_wr_en = commit && (req_type_r == kst_pkg::REQ_TWRITE) &&
                     ({1'b0, table_index_r} < (kst_pkg::TADDR_W + 1)'(TABLE_DEPTH));

  kst_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .wr_en   (tbl_wr_en),
    .wr_addr (table_index_r),
    .wr_data (table_value_r),
    .rd_data (tbl_rdata)
  );

  // scancode translation from the table byte
  always_comb begin
    code_ok  = 1'b0;
    code_val = '0;
    if (!scancode_r[7]) begin
      if (scancode_r <= kst_pkg::KEY_DIRECT_LAST) begin
        code_ok = (tbl_rdata != kst_pkg::TBL_NO_CODE);
        if (scancode_r == kst_pkg::KEY_DIRECT_LAST || scancode_r == kst_pkg::KEY_HIGH_A ||
            scancode_r == kst_pkg::KEY_HIGH_B) begin
          code_val = {tbl_rdata, 8'h00};
        end else begin
          code_val = {scancode_r, tbl_rdata};
        end
      end else if (scancode_r == kst_pkg::KEY_FIXED) begin
        code_ok  = 1'b1;
        code_val = kst_pkg::CODE_FIXED;
      end else if (scancode_r >= kst_pkg::KEY_SHIFTED_LO &&
                   scancode_r <= kst_pkg::KEY_SHIFTED_HI) begin
        code_ok  = (tbl_rdata != kst_pkg::TBL_NO_CODE);
        code_val = {tbl_rdata, 8'h00};
      end
    end
  end

  // ring commands: read at accept; write, drop or clear at commit
  always_comb begin
    ring_cmd.rd_en = accept && (in_req.req_type == kst_pkg::REQ_POP ||
                                in_req.req_type == kst_pkg::REQ_PEEK);
    ring_cmd.push  = commit && (req_type_r == kst_pkg::REQ_SCAN) && code_ok;
    ring_cmd.pop   = commit && (req_type_r == kst_pkg::REQ_POP);
    ring_cmd.clear = commit && (req_type_r == kst_pkg::REQ_CLEAR);
    ring_cmd.wdata = code_val;
  end

  kst_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ring_cmd),
    .rd_data  (ring_rdata),
    .fill     (ring_fill),
    .fill_nxt (ring_fill_nxt)
  );

  // keyboard state update and result fields
  always_comb begin
    logic [7:0] bitm;
    bitm           = 8'd1 << scancode_r[2:0];
    pressed_nxt    = pressed_r;
    shift_nxt      = shift_r;
    retry_nxt      = retry_r;
    key_code_nxt   = '0;
    key_valid_nxt  = 1'b0;
    state_byte_nxt = '0;
    retry_req_nxt  = 1'b0;
    unique case (req_type_r)
      kst_pkg::REQ_SCAN: begin
        retry_nxt = '0;
        if (scancode_r[7]) begin
          pressed_nxt[scancode_r[6:3]] = pressed_r[scancode_r[6:3]] & ~bitm;
          if (scancode_r == kst_pkg::BRK_SHIFT_L || scancode_r == kst_pkg::BRK_SHIFT_R) begin
            shift_nxt = shift_r & 5'b11110;
          end else if (scancode_r >= kst_pkg::BRK_MOD_LO &&
                       scancode_r <= kst_pkg::BRK_MOD_HI) begin
            shift_nxt = shift_r & ~bitm[4:0];
          end
        end else begin
          pressed_nxt[scancode_r[6:3]] = pressed_r[scancode_r[6:3]] | bitm;
          if (scancode_r == kst_pkg::KEY_SHIFT_L || scancode_r == kst_pkg::KEY_SHIFT_R) begin
            shift_nxt = shift_r | 5'b00001;
          end else if (scancode_r >= kst_pkg::KEY_MOD_LO &&
                       scancode_r <= kst_pkg::KEY_MOD_HI) begin
            shift_nxt = shift_r | bitm[4:0];
          end
        end
      end
      kst_pkg::REQ_RXERR: begin
        if (retry_r < kst_pkg::RETRY_LIMIT) begin
          retry_nxt     = retry_r + 1'b1;
          retry_req_nxt = 1'b1;
        end
      end
      kst_pkg::REQ_POP, kst_pkg::REQ_PEEK: begin
        if (ring_fill != '0) begin
          key_code_nxt  = ring_rdata;
          key_valid_nxt = 1'b1;
        end
      end
      kst_pkg::REQ_GROUP: begin
        state_byte_nxt = pressed_r[key_group_r];
      end
      kst_pkg::REQ_CLEAR: begin
        pressed_nxt = '{default: '0};
        shift_nxt   = '0;
        retry_nxt   = '0;
      end
      default: begin
      end
    endcase
    row_nxt = kst_pkg::pick_row(shift_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '{default: '0};
      shift_r   <= '0;
      row_r     <= '0;
      retry_r   <= '0;
    end else if (commit) begin
      pressed_r <= pressed_nxt;
      shift_r   <= shift_nxt;
      row_r     <= row_nxt;
      retry_r   <= retry_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      key_code_r   <= key_code_nxt;
      key_valid_r  <= key_valid_nxt;
      state_byte_r <= state_byte_nxt;
      retry_req_r  <= retry_req_nxt;
      count_r      <= kst_pkg::COUNT_W'(ring_fill_nxt);
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.key_code       = key_code_r;
  assign out_rsp.key_valid      = key_valid_r;
  assign out_rsp.shift_state    = shift_r;
  assign out_rsp.key_state_byte = state_byte_r;
  assign out_rsp.retry_request  = retry_req_r;
  assign out_rsp.buffer_count   = count_r;
  assign out_rsp.table_select   = row_r;

  // checks
  `ASSERT_IMPLIES(a_row_tracks_shift, 1'b1, row_r == kst_pkg::pick_row(shift_r))
  `ASSERT_IMPLIES(a_fill_bound, 1'b1, ring_fill <= FILL_W'(RING_DEPTH))
  `ASSERT_NEXT(a_commit_loads_out, commit, out_valid_r && state_r == ST_IDLE)
  `ASSERT_NEXT(a_accept_starts_exec, accept, state_r == ST_EXEC)

endmodule

@@ tb/sv/keyboard_scancode_translator_fifo_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_fifo_core_tb
// Self-checking bench for the scancode translator with its key code ring.
// A short table of directed requests runs first: empty ring, the resend
// limit, each translate class, the modifiers, a clear and the no-op code.
// Phases of random requests follow, with key chords and press/release pairs
// on random table contents. Each result is compared field by field with its
// typed value or a cycle-free model of pressed map, shift, ring and table.
// ----------------------------------------------------------------------------
module keyboard_scancode_translator_fifo_core_tb;

  localparam logic [kst_pkg::REQ_W-1:0] REQ_NOP = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASES       = RANDOM_ITEMS / PHASE_ITEMS;
  localparam int RING_SLOTS   = kst_pkg::RING_DEPTH_DEF;
  localparam int TABLE_SLOTS  = kst_pkg::TABLE_DEPTH_DEF;
  localparam int PTR_W        = $clog2(RING_SLOTS);
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [kst_pkg::REQ_W-1:0]   req_type;
    logic [kst_pkg::KEY_W-1:0]   scancode;
    logic [kst_pkg::GROUP_W-1:0] key_group;
    logic [kst_pkg::TADDR_W-1:0] table_index;
    logic [kst_pkg::TVAL_W-1:0]  table_value;
  } kbd_req_t;

  typedef struct packed {
    logic [kst_pkg::CODE_W-1:0]  key_code;
    logic                        key_valid;
    logic [kst_pkg::SHIFT_W-1:0] shift_state;
    logic [7:0]                  key_state_byte;
    logic                        retry_request;
    logic [kst_pkg::COUNT_W-1:0] buffer_count;
    logic [kst_pkg::ROW_W-1:0]   table_select;
  } kbd_rsp_t;

  typedef struct packed {
    kbd_req_t rq;
    logic     typed;
    kbd_rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kst_in_if  in_req();
  kst_out_if out_rsp();

  keyboard_scancode_translator_fifo_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  // Shadow keyboard state
  logic [kst_pkg::CODE_W-1:0]  kb_ring [RING_SLOTS];
  logic [PTR_W-1:0]            kb_head;
  logic [PTR_W-1:0]            kb_tail;
  logic [kst_pkg::COUNT_W-1:0] kb_fill;
  logic [7:0]                  kb_pressed [kst_pkg::GROUPS];
  logic [kst_pkg::SHIFT_W-1:0] kb_shift;
  logic [kst_pkg::ROW_W-1:0]   kb_row;
  logic [kst_pkg::RETRY_W-1:0] kb_tally;
  logic [kst_pkg::TVAL_W-1:0]  kb_xlate [TABLE_SLOTS];
  bit                          xlate_loaded [TABLE_SLOTS];

  kbd_rsp_t due_results[$];
  kbd_rsp_t head_rsp;

  int  errors = 0;
  int  results_seen;
  int  items_sent;
  int  codes_queued;
  int  codes_dropped;
  int  retries_granted;
  int  keys_popped;
  int  gap_odds;
  int  stall_odds;
  int  stall_left = 0;
  bit  calm;

  // Row chosen by the shift state: graph, then ctrl, then the low bits
  function automatic logic [kst_pkg::ROW_W-1:0] row_for(
      input logic [kst_pkg::SHIFT_W-1:0] s);
    logic [kst_pkg::ROW_W-1:0] low;
    low = s[2:0];
    if (s[4]) return 3'd7;
    if (s[3]) return 3'd6;
    return (low >= 3'd6) ? low - 3'd2 : low;
  endfunction

  function automatic bit reads_xlate(input logic [kst_pkg::KEY_W-1:0] k);
    return !k[7] && (k <= kst_pkg::KEY_DIRECT_LAST ||
                     (k >= kst_pkg::KEY_SHIFTED_LO && k <= kst_pkg::KEY_SHIFTED_HI));
  endfunction

  // Flat table address; the shifted keys above 0x6B run into the next row
  function automatic logic [kst_pkg::TADDR_W-1:0] xlate_addr(
      input logic [kst_pkg::KEY_W-1:0] k, input logic [kst_pkg::ROW_W-1:0] row);
    int ofs;
    ofs = (k <= kst_pkg::KEY_DIRECT_LAST) ? int'(k) :
          int'(k) - int'(kst_pkg::KEY_SHIFTED_OFS);
    return kst_pkg::TADDR_W'(int'(row) * kst_pkg::ROW_LENGTH + ofs);
  endfunction

  task automatic kb_clear();
    for (int i = 0; i < RING_SLOTS; i++) kb_ring[i] = '0;
    for (int i = 0; i < kst_pkg::GROUPS; i++) kb_pressed[i] = '0;
    kb_head  = '0;
    kb_tail  = '0;
    kb_fill  = '0;
    kb_shift = '0;
    kb_tally = '0;
    kb_row   = row_for('0);
  endtask

  // Applies one request to the shadow state and returns its result
  task automatic compute_response(input kbd_req_t r, output kbd_rsp_t p);
    logic [kst_pkg::KEY_W-1:0]  k;
    logic [7:0]                 bitm;
    logic [kst_pkg::TVAL_W-1:0] v;
    logic [kst_pkg::CODE_W-1:0] code;
    bit                         has_code;
    p        = '0;
    has_code = 1'b0;
    code     = '0;
    k        = r.scancode;
    bitm     = 8'd1 << k[2:0];
    case (r.req_type)
      kst_pkg::REQ_SCAN: begin
        kb_tally = '0;
        if (k[7]) begin
          kb_pressed[k[6:3]] &= ~bitm;
          if (k == kst_pkg::BRK_SHIFT_L || k == kst_pkg::BRK_SHIFT_R) begin
            kb_shift[0] = 1'b0;
          end else if (k >= kst_pkg::BRK_MOD_LO && k <= kst_pkg::BRK_MOD_HI) begin
            kb_shift &= ~bitm[kst_pkg::SHIFT_W-1:0];
          end
        end else begin
          kb_pressed[k[6:3]] |= bitm;
          if (k <= kst_pkg::KEY_DIRECT_LAST) begin
            v = kb_xlate[xlate_addr(k, kb_row)];
            if (v != kst_pkg::TBL_NO_CODE) begin
              has_code = 1'b1;
              if (k == kst_pkg::KEY_DIRECT_LAST || k == kst_pkg::KEY_HIGH_A ||
                  k == kst_pkg::KEY_HIGH_B) begin
                code = {v, 8'h00};
              end else begin
                code = {k, v};
              end
            end
          end else if (k == kst_pkg::KEY_FIXED) begin
            has_code = 1'b1;
            code     = kst_pkg::CODE_FIXED;
          end else if (k >= kst_pkg::KEY_SHIFTED_LO && k <= kst_pkg::KEY_SHIFTED_HI) begin
            v = kb_xlate[xlate_addr(k, kb_row)];
            if (v != kst_pkg::TBL_NO_CODE) begin
              has_code = 1'b1;
              code     = {v, 8'h00};
            end
          end else if (k == kst_pkg::KEY_SHIFT_L || k == kst_pkg::KEY_SHIFT_R) begin
            kb_shift[0] = 1'b1;
          end else if (k >= kst_pkg::KEY_MOD_LO && k <= kst_pkg::KEY_MOD_HI) begin
            kb_shift |= bitm[kst_pkg::SHIFT_W-1:0];
          end
          // full ring drops the new code
          if (has_code) begin
            if (kb_fill < RING_SLOTS) begin
              kb_ring[kb_tail] = code;
              kb_tail++;
              kb_fill++;
              codes_queued++;
            end else begin
              codes_dropped++;
            end
          end
        end
      end
      kst_pkg::REQ_RXERR: begin
        if (kb_tally < kst_pkg::RETRY_LIMIT) begin
          kb_tally++;
          p.retry_request = 1'b1;
          retries_granted++;
        end
      end
      kst_pkg::REQ_POP, kst_pkg::REQ_PEEK: begin
        if (kb_fill != 0) begin
          p.key_code  = kb_ring[kb_head];
          p.key_valid = 1'b1;
          if (r.req_type == kst_pkg::REQ_POP) begin
            kb_head++;
            kb_fill--;
            keys_popped++;
          end
        end
      end
      kst_pkg::REQ_GROUP:  p.key_state_byte = kb_pressed[r.key_group];
      kst_pkg::REQ_TWRITE: kb_xlate[r.table_index] = r.table_value;
      kst_pkg::REQ_CLEAR:  kb_clear();
      default: ;
    endcase
    kb_row         = row_for(kb_shift);
    p.shift_state  = kb_shift;
    p.buffer_count = kb_fill;
    p.table_select = kb_row;
  endtask

  // Random request generators
  function automatic kbd_req_t random_req();
    kbd_req_t r;
    r.req_type    = kst_pkg::REQ_W'($urandom_range(0, 7));
    r.scancode    = kst_pkg::KEY_W'($urandom_range(0, 255));
    r.key_group   = kst_pkg::GROUP_W'($urandom_range(0, 15));
    r.table_index = kst_pkg::TADDR_W'($urandom_range(0, TABLE_SLOTS - 1));
    r.table_value = kst_pkg::TVAL_W'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic kbd_req_t op_req(input logic [kst_pkg::REQ_W-1:0] op);
    kbd_req_t r;
    r = random_req();
    r.req_type = op;
    return r;
  endfunction

  function automatic kbd_req_t scan_req(input logic [kst_pkg::KEY_W-1:0] k);
    kbd_req_t r;
    r = op_req(kst_pkg::REQ_SCAN);
    r.scancode = k;
    return r;
  endfunction

  // Mostly real codes, sometimes the no-code marker
  function automatic logic [kst_pkg::TVAL_W-1:0] table_byte();
    if ($urandom_range(0, 7) == 0) return kst_pkg::TBL_NO_CODE;
    return kst_pkg::TVAL_W'($urandom_range(0, 254));
  endfunction

  function automatic logic [kst_pkg::KEY_W-1:0] pick_char_key();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return kst_pkg::KEY_FIXED;
    if (roll < 5) begin
      return kst_pkg::KEY_W'($urandom_range(kst_pkg::KEY_SHIFTED_LO, kst_pkg::KEY_SHIFTED_HI));
    end
    return kst_pkg::KEY_W'($urandom_range(0, kst_pkg::KEY_DIRECT_LAST));
  endfunction

  function automatic logic [kst_pkg::KEY_W-1:0] pick_mod_key();
    int idx;
    idx = $urandom_range(0, 5);
    return (idx == 5) ? kst_pkg::KEY_SHIFT_R : kst_pkg::KEY_W'(kst_pkg::KEY_SHIFT_L + idx);
  endfunction

  // Mostly keys that only mark the pressed map; 0x5E queues the fixed code, 0x7D sets shift
  function automatic logic [kst_pkg::KEY_W-1:0] pick_plain_key();
    if ($urandom_range(0, 1)) return kst_pkg::KEY_W'($urandom_range(8'h52, 8'h61));
    return kst_pkg::KEY_W'($urandom_range(8'h75, 8'h7F));
  endfunction

  task automatic hold_off(input int n);
    in_req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one request, wait for the accept, then record its result
  task automatic put_request(input kbd_req_t r, input bit typed, input kbd_rsp_t want);
    kbd_rsp_t p;
    if (r.req_type == kst_pkg::REQ_TWRITE) xlate_loaded[r.table_index] = 1'b1;
    in_req.valid       <= 1'b1;
    in_req.req_type    <= r.req_type;
    in_req.scancode    <= r.scancode;
    in_req.key_group   <= r.key_group;
    in_req.table_index <= r.table_index;
    in_req.table_value <= r.table_value;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    compute_response(r, p);
    due_results.push_back(typed ? want : p);
    items_sent++;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      hold_off($urandom_range(1, 17));
    end
  endtask

  // A make code that reads the table gets its entry loaded first
  task automatic send_key(input kbd_req_t r);
    kbd_req_t                    w;
    logic [kst_pkg::TADDR_W-1:0] a;
    if (r.req_type == kst_pkg::REQ_SCAN && reads_xlate(r.scancode)) begin
      a = xlate_addr(r.scancode, kb_row);
      if (!xlate_loaded[a]) begin
        w = op_req(kst_pkg::REQ_TWRITE);
        w.table_index = a;
        w.table_value = table_byte();
        put_request(w, 1'b0, '0);
      end
    end
    put_request(r, 1'b0, '0);
  endtask

  // Modifier held over a few keystrokes, usually released at the end
  task automatic key_chord();
    logic [kst_pkg::KEY_W-1:0] m;
    logic [kst_pkg::KEY_W-1:0] c;
    m = pick_mod_key();
    send_key(scan_req(m));
    repeat ($urandom_range(1, 4)) begin
      c = pick_char_key();
      send_key(scan_req(c));
      if ($urandom_range(0, 1)) send_key(scan_req(c | 8'h80));
    end
    if ($urandom_range(0, 4) != 0) send_key(scan_req(m | 8'h80));
  endtask

  task automatic random_step(input int kind);
    int                        roll;
    int                        pop_w;
    int                        chord_w;
    logic [kst_pkg::KEY_W-1:0] k;
    kbd_req_t                  w;
    pop_w   = (kind == 1) ? 3 : (kind == 2) ? 40 : 14;
    chord_w = (kind == 3) ? 45 : 30;
    roll    = $urandom_range(0, 99);
    if (roll < pop_w) begin
      send_key(op_req(($urandom_range(0, 2) == 0) ? kst_pkg::REQ_PEEK : kst_pkg::REQ_POP));
    end else if (roll < pop_w + 6) begin
      // resend bursts run past the limit now and then
      repeat ($urandom_range(1, 5)) send_key(op_req(kst_pkg::REQ_RXERR));
    end else if (roll < pop_w + 11) begin
      send_key(op_req(kst_pkg::REQ_GROUP));
    end else if (roll < pop_w + 17) begin
      k = table_byte();
      w = op_req(kst_pkg::REQ_TWRITE);
      w.table_value = k;
      put_request(w, 1'b0, '0);
    end else if (roll < pop_w + 18 && kind != 1) begin
      send_key(op_req(kst_pkg::REQ_CLEAR));
    end else if (roll < pop_w + 21) begin
      // noise: any request code with any fields
      send_key(random_req());
    end else if (roll < pop_w + chord_w) begin
      key_chord();
    end else begin
      k = ($urandom_range(0, 5) == 0) ? pick_plain_key() : pick_char_key();
      send_key(scan_req(k));
      if ($urandom_range(0, 1)) send_key(scan_req(k | 8'h80));
    end
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic dir_row_t drow(input logic [kst_pkg::REQ_W-1:0] op,
                                    input logic [kst_pkg::KEY_W-1:0] k,
                                    input logic [kst_pkg::TADDR_W-1:0] idx,
                                    input logic [kst_pkg::TVAL_W-1:0] val,
                                    input logic typed, input kbd_rsp_t want);
    dir_row_t d;
    d.rq          = '0;
    d.rq.req_type = op;
    d.rq.scancode = k;
    d.rq.key_group = (op == kst_pkg::REQ_GROUP) ? k[3:0] : '0;
    d.rq.table_index = idx;
    d.rq.table_value = val;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        head_rsp = due_results.pop_front();
        check_field("key_code",       32'(head_rsp.key_code),       32'(out_rsp.key_code));
        check_field("key_valid",      32'(head_rsp.key_valid),      32'(out_rsp.key_valid));
        check_field("shift_state",    32'(head_rsp.shift_state),    32'(out_rsp.shift_state));
        check_field("key_state_byte", 32'(head_rsp.key_state_byte),
                    32'(out_rsp.key_state_byte));
        check_field("retry_request",  32'(head_rsp.retry_request),
                    32'(out_rsp.retry_request));
        check_field("buffer_count",   32'(head_rsp.buffer_count),   32'(out_rsp.buffer_count));
        check_field("table_select",   32'(head_rsp.table_select),   32'(out_rsp.table_select));
      end
    end
  end

  // Receiver back-pressure: ready drops in random bursts, held high while calm or in reset
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_rsp.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_rsp.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 16);
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t dir_rows[$];
    kbd_rsp_t zero_rsp;
    kbd_rsp_t retry_rsp;
    int       kind;

    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.req_type    <= '0;
    in_req.scancode    <= '0;
    in_req.key_group   <= '0;
    in_req.table_index <= '0;
    in_req.table_value <= '0;
    calm        = 1'b0;
    gap_odds    = 4;
    stall_odds  = 4;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      kb_xlate[i]     = '0;
      xlate_loaded[i] = 1'b0;
    end
    kb_clear();

    zero_rsp  = '0;
    retry_rsp = '0;
    retry_rsp.retry_request = 1'b1;

    // Directed requests: empty ring and resend limit straight after reset
    dir_rows.push_back(drow(kst_pkg::REQ_POP,    8'h00, 10'd0, 8'h00, 1'b1, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_PEEK,   8'h00, 10'd0, 8'h00, 1'b1, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_RXERR,  8'h00, 10'd0, 8'h00, 1'b1, retry_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_RXERR,  8'h00, 10'd0, 8'h00, 1'b1, retry_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_RXERR,  8'h00, 10'd0, 8'h00, 1'b1, retry_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_RXERR,  8'h00, 10'd0, 8'h00, 1'b1, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_GROUP,  8'h0F, 10'd0, 8'h00, 1'b1, zero_rsp));
    // Table entries for the translate classes in row 0, and the top table entry
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'd0,  8'hA5, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'h35, 8'h12, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'h51, kst_pkg::TBL_NO_CODE,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'h56, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'd99, 8'h7E, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_TWRITE, 8'h00, 10'd1023, kst_pkg::TBL_NO_CODE,
                            1'b0, zero_rsp));
    // Direct, high-byte, no-code, fixed, shifted and next-row keys
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, 8'h00, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_HIGH_A, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_DIRECT_LAST, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_FIXED, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_SHIFTED_LO, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_SHIFTED_HI, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    // Shift then graph; a key in the no-shift window; read its group
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_SHIFT_L, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::KEY_MOD_HI, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN,  8'h55, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_GROUP, 8'h0A, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_POP,   8'h00, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN, kst_pkg::BRK_MOD_HI, 10'd0, 8'h00,
                            1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_SCAN,  8'hFF, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(REQ_NOP,            8'h00, 10'd0, 8'h00, 1'b0, zero_rsp));
    dir_rows.push_back(drow(kst_pkg::REQ_CLEAR, 8'h00, 10'd0, 8'h00, 1'b1, zero_rsp));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].typed) put_request(dir_rows[i].rq, 1'b1, dir_rows[i].want);
      else send_key(dir_rows[i].rq);
    end
    drain();

    // Random phases; each ends with the sender waiting for every result
    for (int ph = 0; ph < PHASES; ph++) begin
      kind       = ph % 4;
      calm       = (ph == PHASES - 1);
      gap_odds   = (kind == 0) ? 6 : (kind == 1) ? 10 : (kind == 2) ? 0 : 5;
      stall_odds = (kind == 0) ? 6 : (kind == 1) ? 4 : (kind == 2) ? 10 : 0;
      begin
        int stop;
        stop = items_sent + PHASE_ITEMS;
        while (items_sent < stop) random_step(kind);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d requests, %0d results checked, %0d key codes queued, %0d dropped full",
             items_sent, results_seen, codes_queued, codes_dropped);
    $display("     %0d keys popped, %0d resend requests granted", keys_popped, retries_granted);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
